>>> hdl/gradient_noise_2d_unit_assert.svh
// Assertion macros shared by the checker file.
`ifndef GRADIENT_NOISE_2D_UNIT_ASSERT_SVH
`define GRADIENT_NOISE_2D_UNIT_ASSERT_SVH

// Same-cycle implication, off while rst is high.
`define GN2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while rst is high.
`define GN2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs during reset.
`define GN2D_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gn2d_pkg.sv
`timescale 1ns / 1ps

package gn2d_pkg;

  // port widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // item kinds carried on s_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // register index, paddr[2]
  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Y = 1'b1;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // datapath widths: dot product, x blend, y blend
  localparam int DOT_W = 26;
  localparam int IX_W  = 36;
  localparam int V_W   = 46;
  localparam int Q_W   = V_W - 24;

  localparam logic signed [V_W-1:0] ROUND_HALF = V_W'(64'sd8388608);

  // classified item handed from front to back
  typedef struct packed {
    logic        is_eval;
    logic        oor;      // evaluate item whose cell leaves the table
    logic        wr_en;    // write item that lands inside the table
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [7:0]  col;      // cell column (evaluate) or node column (write)
    logic [7:0]  row;
    logic [31:0] grad;     // {grad_y, grad_x}
  } gn2d_item_t;

  // per-item control riding along the back pipeline
  typedef struct packed {
    logic       is_eval;
    logic       oor;
    logic [7:0] fx;
    logic [7:0] fy;
  } gn2d_meta_t;

endpackage

>>> hdl/gradient_noise_2d_unit.sv
`timescale 1ns / 1ps

// 2-D Perlin gradient noise with linear blend weights. Each input beat is
// either a gradient write (s_tuser = 0) that stores one node's UQ1.15 pair,
// or a point evaluation (s_tuser = 1) of a Q8.8 coordinate; every beat gives
// exactly one result beat, in order: Q1.15 noise, saturated, with
// m_tuser set (and noise zero) when the 2x2 cell around the point is not
// inside the GRID_W x GRID_H table placed at (grid_origin_x, grid_origin_y).
// Writes give zero. The block takes one beat per clock unless the result
// stream stalls; four table banks, split by node column and row parity, each
// read one gradient per cycle so the four corners of a cell come in a single
// access. A beat passes the front register, queue, memory read, dot products,
// x blend, y blend and output register. The gradient table is not cleared by
// reset: load every node that points will touch before evaluating. The user
// must change grid_origin_x/y (APB offsets 0x0 and 0x4, 8-bit signed, read
// back sign-extended) only while idle; the block does not enforce this.

module gradient_noise_2d_unit import gn2d_pkg::*; #(
  parameter int GRID_W = 16,
  parameter int GRID_H = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // point_x[15:0], point_y[31:16], node_col[35:32], node_row[39:36],
  // grad_x[55:40], grad_y[71:56]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode[0]
  input  logic                   s_tuser,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // noise_value[15:0]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // out_of_range[0]
  output logic                   m_tuser,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  logic signed [7:0] origin_x, origin_y;
  logic              q_in_valid, q_in_ready;
  gn2d_item_t        q_in_item;
  logic              q_out_valid, q_out_ready;
  gn2d_item_t        q_out_item;

  // register file: no wait states, offset decoded on paddr[2]
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ORIGIN_X: origin_x <= pwdata[7:0];
        REG_ORIGIN_Y: origin_y <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ORIGIN_X: prdata = {{(CFG_DW - 8){origin_x[7]}}, origin_x};
      REG_ORIGIN_Y: prdata = {{(CFG_DW - 8){origin_y[7]}}, origin_y};
      default:      prdata = '0;
    endcase
  end

  // front: takes beats, locates the cell, range-checks, registers
  gn2d_front #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_item   (q_in_item)
  );

  // short queue decouples classification from the arithmetic pipeline
  gn2d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_item   (q_in_item),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_item  (q_out_item)
  );

  // back: banked gradient table, dot products, blends, round and clamp
  gn2d_back #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_out_valid),
    .q_ready  (q_out_ready),
    .q_item   (q_out_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> hdl/gn2d_front.sv
`timescale 1ns / 1ps

module gn2d_front import gn2d_pkg::*; #(
  parameter int GRID_W = 16,
  parameter int GRID_H = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  logic signed [7:0]     origin_x,
  input  logic signed [7:0]     origin_y,
  output logic                  q_valid,
  input  logic                  q_ready,
  output gn2d_item_t            q_item
);

  localparam logic signed [9:0] COL_LAST = 10'(GRID_W - 2);
  localparam logic signed [9:0] ROW_LAST = 10'(GRID_H - 2);
  localparam logic [8:0]        GW9      = 9'(GRID_W);
  localparam logic [8:0]        GH9      = 9'(GRID_H);

  logic [15:0]       px, py;
  logic [3:0]        node_col, node_row;
  logic signed [9:0] c0, r0;
  logic              cell_ok, wr_ok, is_eval;
  gn2d_item_t        item;
  logic              hold_valid;
  gn2d_item_t        hold_item;

  assign px       = s_tdata[15:0];
  assign py       = s_tdata[31:16];
  assign node_col = s_tdata[35:32];
  assign node_row = s_tdata[39:36];
  assign is_eval  = (s_tuser == OP_EVAL);

  // floor(p/256) is the integer byte; cell index relative to the origin
  assign c0 = {{2{px[15]}}, px[15:8]} - {{2{origin_x[7]}}, origin_x};
  assign r0 = {{2{py[15]}}, py[15:8]} - {{2{origin_y[7]}}, origin_y};

  // both neighbors are needed even at zero weight
  assign cell_ok = (c0 >= 10'sd0) && (c0 <= COL_LAST) &&
                   (r0 >= 10'sd0) && (r0 <= ROW_LAST);
  assign wr_ok   = ({5'd0, node_col} < GW9) && ({5'd0, node_row} < GH9);

  always_comb begin
    item.is_eval = is_eval;
    item.oor     = is_eval && !cell_ok;
    item.wr_en   = !is_eval && wr_ok;
    item.fx      = px[7:0];
    item.fy      = py[7:0];
    item.col     = is_eval ? c0[7:0] : {4'd0, node_col};
    item.row     = is_eval ? r0[7:0] : {4'd0, node_row};
    item.grad    = s_tdata[71:40];
  end

  assign s_tready = !hold_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      hold_item <= item;
    end
  end

  assign q_valid = hold_valid;
  assign q_item  = hold_item;

endmodule

>>> hdl/gn2d_queue.sv
`timescale 1ns / 1ps

module gn2d_queue import gn2d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  gn2d_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output gn2d_item_t out_item
);

  gn2d_item_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count, count_next;
  logic              push, pop;

  assign in_ready  = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

>>> hdl/gn2d_back.sv
`timescale 1ns / 1ps

module gn2d_back import gn2d_pkg::*; #(
  parameter int GRID_W = 16,
  parameter int GRID_H = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  gn2d_item_t             q_item,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser
);

  // four banks split by column and row parity: one corner per bank
  localparam int HB         = (GRID_W + 1) / 2;
  localparam int VB         = (GRID_H + 1) / 2;
  localparam int BANK_DEPTH = HB * VB;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic [AW-1:0] bank_addr(input logic [7:0] r, input logic [7:0] c);
    bank_addr = AW'(int'(r[7:1]) * HB + int'(c[7:1]));
  endfunction

  logic                         en0, en1, en2, en3, en_o, fire;
  logic                         vld0, vld1, vld2, vld3, o_valid;
  gn2d_meta_t                   meta0, meta1, meta2, meta3;
  logic                         swap_x, swap_y;
  logic [3:0][31:0]             rdata;
  logic signed [3:0][DOT_W-1:0] dot, dot_next;
  logic signed [IX_W-1:0]       ix0, ix1, ix0_next, ix1_next;
  logic signed [V_W-1:0]        blend, blend_next;
  logic signed [V_W-1:0]        rounded;
  logic signed [Q_W-1:0]        q_val;
  logic [15:0]                  sat, o_noise;
  logic                         o_oor;

  // a stage loads when it is empty or its successor loads
  assign en_o    = !o_valid || m_tready;
  assign en3     = !vld3 || en_o;
  assign en2     = !vld2 || en3;
  assign en1     = !vld1 || en2;
  assign en0     = !vld0 || en1;
  assign q_ready = en0;
  assign fire    = q_valid && en0;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);

    logic [7:0]    colb, rowb;
    logic [AW-1:0] addr;
    logic          we, re;
    logic [31:0]   grad_mem [BANK_DEPTH];

    assign colb = (q_item.col[0] == CP) ? q_item.col : q_item.col + 8'd1;
    assign rowb = (q_item.row[0] == RP) ? q_item.row : q_item.row + 8'd1;
    assign addr = bank_addr(rowb, colb);
    assign we   = fire && q_item.wr_en && (q_item.col[0] == CP) && (q_item.row[0] == RP);
    assign re   = fire && q_item.is_eval && !q_item.oor;

    always_ff @(posedge clk) begin
      if (we) begin
        grad_mem[addr] <= q_item.grad;
      end
      if (re) begin
        rdata[b] <= grad_mem[addr];
      end
    end
  end

  // corner k = {cy, cx}; its bank is k with the cell parity folded in
  always_comb begin
    logic [1:0]              kk;
    logic [1:0]              bsel;
    logic signed [8:0]       dx, dy;
    logic signed [16:0]      gx, gy;
    for (int k = 0; k < 4; k++) begin
      kk   = 2'(k);
      bsel = kk ^ {swap_y, swap_x};
      dx   = {kk[0], meta0.fx};
      dy   = {kk[1], meta0.fy};
      gx   = {1'b0, rdata[bsel][15:0]};
      gy   = {1'b0, rdata[bsel][31:16]};
      dot_next[k] = DOT_W'(dx) * DOT_W'(gx) + DOT_W'(dy) * DOT_W'(gy);
    end
  end

  // elements of a packed array select as unsigned: re-sign each dot product
  always_comb begin
    logic signed [9:0] w_lo, w_hi;
    w_lo     = $signed(10'd256 - {2'd0, meta1.fx});
    w_hi     = $signed({2'd0, meta1.fx});
    ix0_next = IX_W'($signed(dot[0])) * IX_W'(w_lo) + IX_W'($signed(dot[1])) * IX_W'(w_hi);
    ix1_next = IX_W'($signed(dot[2])) * IX_W'(w_lo) + IX_W'($signed(dot[3])) * IX_W'(w_hi);
  end

  always_comb begin
    logic signed [9:0] w_lo, w_hi;
    w_lo       = $signed(10'd256 - {2'd0, meta2.fy});
    w_hi       = $signed({2'd0, meta2.fy});
    blend_next = V_W'(ix0) * V_W'(w_lo) + V_W'(ix1) * V_W'(w_hi);
  end

  // round half up to Q1.15, then clamp
  assign rounded = blend + ROUND_HALF;
  assign q_val   = rounded[V_W-1:24];

  always_comb begin
    if (q_val[Q_W-1:15] == {(Q_W - 15){q_val[Q_W-1]}}) begin
      sat = q_val[15:0];
    end else if (q_val[Q_W-1]) begin
      sat = 16'h8000;
    end else begin
      sat = 16'h7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0    <= 1'b0;
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (en0) vld0 <= q_valid;
      if (en1) vld1 <= vld0;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
      if (en_o) o_valid <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      meta0.is_eval <= q_item.is_eval;
      meta0.oor     <= q_item.oor;
      meta0.fx      <= q_item.fx;
      meta0.fy      <= q_item.fy;
      swap_x        <= q_item.col[0];
      swap_y        <= q_item.row[0];
    end
    if (en1) begin
      meta1 <= meta0;
      dot   <= dot_next;
    end
    if (en2) begin
      meta2 <= meta1;
      ix0   <= ix0_next;
      ix1   <= ix1_next;
    end
    if (en3) begin
      meta3 <= meta2;
      blend <= blend_next;
    end
    if (en_o) begin
      o_noise <= (meta3.is_eval && !meta3.oor) ? sat : 16'd0;
      o_oor   <= meta3.is_eval && meta3.oor;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_noise;
  assign m_tuser  = o_oor;

endmodule

>>> hdl/gn2d_checker.sv
`timescale 1ns / 1ps

`include "gradient_noise_2d_unit_assert.svh"

module gn2d_checker import gn2d_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [CFG_AW-1:0]      paddr,
  input logic [CFG_DW-1:0]      pwdata,
  input logic [CFG_DW-1:0]      prdata,
  input logic                   pready
);

  // a stalled result beat holds
  `GN2D_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // a cell off the table always reports zero noise
  `GN2D_ASSERT_IMP(a_oor_zero, m_tvalid && m_tuser, m_tdata == '0, "out-of-range result with nonzero noise")

  // x origin reads back what was written
  `GN2D_ASSERT_NXT(a_cfg_readback, psel && penable && pwrite && pready && paddr[2] == REG_ORIGIN_X, paddr[2] != REG_ORIGIN_X || prdata[7:0] == $past(pwdata[7:0]), "origin x readback mismatch")

  // reset empties the pipeline and opens the input
  `GN2D_ASSERT_RST(a_reset_idle, rst, !m_tvalid && s_tready, "not idle after reset")

endmodule

bind gradient_noise_2d_unit gn2d_checker u_checker (.*);
